@@ src/sapq_pkg.sv @@
package sapq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } ctl_t;

endpackage

@@ src/sapq_req_if.sv @@
interface sapq_req_if
  import sapq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  op_t                          op;
  logic signed [DATA_WIDTH-1:0] value_in;

  modport source (output valid, output op, output value_in, input ready);
  modport sink   (input valid, input op, input value_in, output ready);
endinterface

@@ src/sapq_rsp_if.sv @@
interface sapq_rsp_if
  import sapq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  status_t                      status;
  logic signed [DATA_WIDTH-1:0] value_out;
  logic        [CNT_W-1:0]      live_count;

  modport source (output valid, output status, output value_out, output live_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input live_count,
                  output ready);
endinterface

@@ src/sorted_array_priority_queue.sv @@
// Sorted priority queue built from a row of compare-and-shift cells.
// The response is registered: it turns valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response side is ready; every cell compares and shifts in parallel.
// Reset (rst, synchronous): queue empty, both indices zero, no response pending.
// Entry contents are not cleared by reset.
module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input logic        clk,
  input logic        rst,
  sapq_req_if.sink   req,
  sapq_rsp_if.source rsp
);

  localparam logic [CNT_W-1:0] FULL_IDX = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  logic [CNT_W-1:0] end_idx;
  logic [CNT_W-1:0] end_idx_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                         rsp_valid;
  status_t                      rsp_status;
  status_t                      status_next;
  logic signed [DATA_WIDTH-1:0] rsp_value;
  logic signed [DATA_WIDTH-1:0] value_next;
  logic        [CNT_W-1:0]      rsp_count;

  logic accept;
  logic full;
  logic empty;
  ctl_t ctl;

  logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                         cell_gt   [DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = end_idx == FULL_IDX;
  assign empty     = count == '0;
  assign ctl.enq   = accept && (req.op == OP_ENQ) && !full;
  assign ctl.deq   = accept && (req.op == OP_DEQ) && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic                         left_gt;
      logic signed [DATA_WIDTH-1:0] right_data;

      if (g == 0) begin : g_first
        assign left_data = cell_data[g];
        assign left_gt   = 1'b0;
      end else begin : g_mid
        assign left_data = cell_data[g-1];
        assign left_gt   = cell_gt[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign right_data = cell_data[g];
      end else begin : g_inner
        assign right_data = cell_data[g+1];
      end

      sapq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX        (g)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .value_new  (req.value_in),
        .left_data  (left_data),
        .left_gt    (left_gt),
        .right_data (right_data),
        .data       (cell_data[g]),
        .gt         (cell_gt[g])
      );
    end
  endgenerate

  always_comb begin
    end_idx_next = end_idx;
    count_next   = count;
    status_next  = ST_DONE;
    value_next   = '0;
    unique case (req.op)
      OP_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          end_idx_next = end_idx + ONE;
          count_next   = count + ONE;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_next  = ST_EMPTY;
          end_idx_next = '0;
        end else begin
          value_next = cell_data[0];
          count_next = count - ONE;
          if (count == ONE) begin
            end_idx_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_idx   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        end_idx   <= end_idx_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_value  <= value_next;
      rsp_count  <= count_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.value_out  = rsp_value;
  assign rsp.live_count = rsp_count;

endmodule

@@ src/sapq_cell.sv @@
module sapq_cell
  import sapq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH_DEF + 1),
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  ctl_t                         ctl,
  input  logic        [CNT_W-1:0]      count,
  input  logic signed [DATA_WIDTH-1:0] value_new,
  input  logic signed [DATA_WIDTH-1:0] left_data,
  input  logic                         left_gt,
  input  logic signed [DATA_WIDTH-1:0] right_data,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         gt
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  logic live;
  logic at_end;

  assign live   = POS < count;
  assign at_end = POS == count;
  assign gt     = live && (data > value_new);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (left_gt) begin
        data <= left_data;
      end else if (gt || at_end) begin
        data <= value_new;
      end
    end else if (ctl.deq) begin
      data <= right_data;
    end
  end

endmodule

@@ dv/sapq_checker.sv @@
`timescale 1ns / 1ps

module sapq_checker
  import sapq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sapq_req_if  req,
  sapq_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   full_hits,
  output int   empty_hits
);

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int CNT_W = $clog2(DEPTH_DEF + 1);

  typedef struct packed {
    status_t                status;
    logic signed [DW-1:0]   value;
    logic        [CNT_W-1:0] count;
  } rsp_t;

  logic signed [DW-1:0] slots [DEPTH_DEF];
  int                   head;
  int                   tail;
  rsp_t                 due_q [$];

  function automatic rsp_t step_queue(input op_t op, input logic signed [DW-1:0] v);
    rsp_t r;
    int   i;
    r.status = ST_DONE;
    r.value  = '0;
    if (op == OP_ENQ) begin
      if (tail >= DEPTH_DEF) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        i = tail;
        while (i > head && slots[i-1] > v) begin
          slots[i] = slots[i-1];
          i--;
        end
        slots[i] = v;
        tail++;
      end
    end else if (head >= tail) begin
      head = 0;
      tail = 0;
      r.status = ST_EMPTY;
      empty_hits++;
    end else begin
      r.value = slots[head];
      head++;
      if (head >= tail) begin
        head = 0;
        tail = 0;
      end
    end
    r.count = CNT_W'(tail - head);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      head = 0;
      tail = 0;
      due_q.delete();
    end else begin
      if (req.valid && req.ready)
        due_q.push_back(step_queue(req.op, req.value_in));
      if (rsp.valid && rsp.ready) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: response with none expected: status %0d value %0d count %0d",
                   $time, rsp.status, rsp.value_out, rsp.live_count);
        end else begin
          want = due_q.pop_front();
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          end
          if (rsp.value_out !== want.value) begin
            errors++;
            $display("%0t: value_out expected %0d got %0d", $time, want.value,
                     rsp.value_out);
          end
          if (rsp.live_count !== want.count) begin
            errors++;
            $display("%0t: live_count expected %0d got %0d", $time, want.count,
                     rsp.live_count);
          end
        end
      end
    end
    pending = due_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sapq_pkg::*;

  localparam int ITEMS = 550;

  logic clk;
  logic rst;
  bit   calm;
  int   sent;
  int   errors;
  int   pending;
  int   full_hits;
  int   empty_hits;

  sapq_req_if req_ch ();
  sapq_rsp_if rsp_ch ();

  sorted_array_priority_queue uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sapq_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .errors     (errors),
    .pending    (pending),
    .full_hits  (full_hits),
    .empty_hits (empty_hits)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input op_t op, input logic signed [31:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.value_in <= v;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  // response side: drop ready for a random stall before each response, with no stall while calm
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int len;
    int enq_pct;
    op_t op;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_ENQ;
    req_ch.value_in = '0;
    calm            = 1'b0;
    sent            = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(OP_DEQ, $urandom);
    send(OP_ENQ, 32'sh7fffffff);
    send(OP_ENQ, 32'sh80000000);
    send(OP_ENQ, '0);
    send(OP_ENQ, -32'sd1);
    send(OP_ENQ, -32'sd1);
    send(OP_ENQ, 32'sd1);
    send(OP_DEQ, $urandom);
    send(OP_DEQ, $urandom);
    // fill the rear while the front has moved up
    repeat (10) send(OP_ENQ, pick_value());
    send(OP_ENQ, pick_value());
    send(OP_DEQ, $urandom);
    send(OP_ENQ, 32'sh7fffffff);
    hold_until_drained();

    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: enq_pct = 25;
        1: enq_pct = 50;
        default: enq_pct = 75;
      endcase
      len = $urandom_range(20, 60);
      if (len > ITEMS - sent)
        len = ITEMS - sent;
      repeat (len) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send(op, pick_value());
      end
      if ($urandom_range(0, 2) == 0)
        hold_until_drained();
    end

    calm = 1'b0;
    req_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (5) @(posedge clk);
    $display("Ran %0d requests across fill, drain and mixed phases with random stalls.", sent);
    $display("Queue refused %0d enqueues as full and %0d dequeues as empty.",
             full_hits, empty_hits);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
